// ===== rtl/core/pgh_pkg.sv =====
package pgh_pkg;

    // Grid size defaults
    localparam int GRID_ROWS_DEF = 512;
    localparam int GRID_COLS_DEF = 512;

    // Field widths
    localparam int COORD_W    = 16;
    localparam int CELL_W     = 14;
    localparam int IDX_IN_W   = 9;
    localparam int COUNT_W    = 8;
    localparam int SPAN_W     = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 16;

    // Margin added to the x span before it is divided into columns
    localparam logic signed [SPAN_W-1:0] SPAN_MARGIN = 18'sd1000;

    // Command codes
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_X     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y     = 3'd4;

    // Register reset values
    localparam logic [CELL_W-1:0]         CELL_SIZE_RST = 14'd50;
    localparam logic signed [COORD_W-1:0] MIN_X_RST     = -16'sd10000;
    localparam logic signed [COORD_W-1:0] MAX_X_RST     = 16'sd10000;
    localparam logic signed [COORD_W-1:0] MIN_Y_RST     = -16'sd10000;
    localparam logic signed [COORD_W-1:0] MAX_Y_RST     = 16'sd10000;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_ADDR,
        ST_READ,
        ST_WRITE
    } t_state;

endpackage

// ===== rtl/core/point_grid_histogram.sv =====
// Point grid histogram: bins 2D points (millimetres) into a store of 8-bit
// saturating hit counts held in one synchronous RAM.
//
// Input stream: one beat per command. tuser carries the command (add a point
// or read-and-clear one cell); tdata carries the point and the cell address.
// Output stream: exactly one beat per input beat, in order, carrying the
// counted flag and the cell count. Registers are written through a plain
// write port, only while idle: a user rule the block does not enforce.
//
// Each item passes from acceptance through the bit-serial dividers that turn
// offsets into row/column and the x span into the grid width (17 steps for the
// span), then multiply, address add, RAM read and write-back to its result
// beat.
// The next beat is accepted in the cycle after the result is registered,
// so the block takes no new item until the last one is through.
//
// After reset the store is cleared one entry a cycle, all GRID_ROWS*GRID_COLS
// entries, with tready low; register writes are still taken then.
// If the receiver stalls, the result waits in the output register; a
// following item runs up to its write-back and holds there until the
// earlier beat is taken.
module point_grid_histogram #(
    parameter int GRID_ROWS = pgh_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = pgh_pkg::GRID_COLS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // [15:0] point_x, [31:16] point_y, [40:32] cell_row, [49:41] cell_col
    input  logic [pgh_pkg::S_TDATA_W-1:0]    i_s_tdata,
    // [0] command
    input  logic                             i_s_tuser,
    // Output stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [0] point_counted, [8:1] cell_count
    output logic [pgh_pkg::M_TDATA_W-1:0]    o_m_tdata,
    // Register write port
    input  logic                             i_cfg_we,
    input  logic [pgh_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pgh_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int DEPTH   = GRID_ROWS * GRID_COLS;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CRD_W   = pgh_pkg::COORD_W;
    localparam int CELL_W  = pgh_pkg::CELL_W;
    localparam int IIN_W   = pgh_pkg::IDX_IN_W;
    localparam int CNT_W   = pgh_pkg::COUNT_W;
    localparam int SPAN_W  = pgh_pkg::SPAN_W;
    localparam int SQ_W    = SPAN_W - 1;
    localparam int WCOL_W  = $clog2(GRID_COLS + 1);
    localparam int PROD_W  = CRD_W + WCOL_W;
    localparam int IDX_W   = PROD_W + 1;

    localparam logic [IDX_W-1:0]  DEPTH_I   = IDX_W'(DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [SQ_W-1:0]   COLS_Q    = SQ_W'(GRID_COLS);
    localparam logic [WCOL_W-1:0] COLS_W    = WCOL_W'(GRID_COLS);

    // Configuration registers
    logic [CELL_W-1:0]       r_cell_size;
    logic signed [CRD_W-1:0] r_min_x;
    logic signed [CRD_W-1:0] r_max_x;
    logic signed [CRD_W-1:0] r_min_y;
    logic signed [CRD_W-1:0] r_max_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_size <= pgh_pkg::CELL_SIZE_RST;
            r_min_x     <= pgh_pkg::MIN_X_RST;
            r_max_x     <= pgh_pkg::MAX_X_RST;
            r_min_y     <= pgh_pkg::MIN_Y_RST;
            r_max_y     <= pgh_pkg::MAX_Y_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pgh_pkg::CFG_CELL_SIZE: r_cell_size <= i_cfg_data[CELL_W-1:0];
                pgh_pkg::CFG_MIN_X:     r_min_x     <= i_cfg_data;
                pgh_pkg::CFG_MAX_X:     r_max_x     <= i_cfg_data;
                pgh_pkg::CFG_MIN_Y:     r_min_y     <= i_cfg_data;
                pgh_pkg::CFG_MAX_Y:     r_max_y     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Unpack the input beat
    logic                    in_cmd;
    logic signed [CRD_W-1:0] in_x;
    logic signed [CRD_W-1:0] in_y;
    logic [IIN_W-1:0]        in_row;
    logic [IIN_W-1:0]        in_col;

    assign in_cmd = i_s_tuser;
    assign in_x   = i_s_tdata[CRD_W-1:0];
    assign in_y   = i_s_tdata[2*CRD_W-1:CRD_W];
    assign in_row = i_s_tdata[2*CRD_W+IIN_W-1:2*CRD_W];
    assign in_col = i_s_tdata[2*CRD_W+2*IIN_W-1:2*CRD_W+IIN_W];

    pgh_pkg::t_state r_state;
    pgh_pkg::t_state n_state;

    logic accept;
    assign o_s_tready = (r_state == pgh_pkg::ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;

    // Box test, offsets and x span, taken at acceptance
    logic signed [CRD_W:0]   x_diff;
    logic signed [CRD_W:0]   y_diff;
    logic signed [SPAN_W-1:0] span;
    logic                    in_box;
    logic                    span_pos;
    logic [CELL_W-1:0]       eff_cell;

    assign x_diff   = {in_x[CRD_W-1], in_x} - {r_min_x[CRD_W-1], r_min_x};
    assign y_diff   = {in_y[CRD_W-1], in_y} - {r_min_y[CRD_W-1], r_min_y};
    assign span     = {{2{r_max_x[CRD_W-1]}}, r_max_x}
                    - {{2{r_min_x[CRD_W-1]}}, r_min_x} + pgh_pkg::SPAN_MARGIN;
    assign span_pos = !span[SPAN_W-1] && (span != '0);
    assign in_box   = (in_x > r_min_x) && (in_x < r_max_x)
                   && (in_y > r_min_y) && (in_y < r_max_y);
    // A zero cell size counts as one millimetre
    assign eff_cell = (r_cell_size == '0) ? CELL_W'(1) : r_cell_size;

    // Dividers: row, column and grid width run side by side
    logic             row_busy, col_busy, span_busy;
    logic [CRD_W-1:0] row_q, col_q;
    logic [SQ_W-1:0]  span_q;

    pgh_div #(.NUM_W(CRD_W), .DEN_W(CELL_W)) u_div_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_num   (y_diff[CRD_W-1:0]),
        .i_den   (eff_cell),
        .o_busy  (row_busy),
        .o_quo   (row_q)
    );

    pgh_div #(.NUM_W(CRD_W), .DEN_W(CELL_W)) u_div_col (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_num   (x_diff[CRD_W-1:0]),
        .i_den   (eff_cell),
        .o_busy  (col_busy),
        .o_quo   (col_q)
    );

    pgh_div #(.NUM_W(SQ_W), .DEN_W(CELL_W)) u_div_span (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_num   (span_pos ? span[SQ_W-1:0] : '0),
        .i_den   (eff_cell),
        .o_busy  (span_busy),
        .o_quo   (span_q)
    );

    logic div_done;
    assign div_done = !row_busy && !col_busy && !span_busy;

    // Item registers
    logic              r_cmd;
    logic              r_in_box;
    logic              r_span_pos;
    logic [IIN_W-1:0]  r_row_in;
    logic [IIN_W-1:0]  r_col_in;
    logic [WCOL_W-1:0] r_width;
    logic [PROD_W-1:0] r_prod;
    logic [IDX_W-1:0]  r_idx;
    logic              r_hit;
    logic [ADDR_W-1:0] r_clr_addr;

    // Output register
    logic              r_out_valid;
    logic              r_out_counted;
    logic [CNT_W-1:0]  r_out_count;

    logic [CRD_W-1:0]  row_sel, col_sel;
    logic [WCOL_W-1:0] width_c;
    logic [IDX_W-1:0]  idx_c;
    logic              out_free;
    logic              wb_go;

    // Read items address the grid directly; add items use the quotients
    assign row_sel = (r_cmd == pgh_pkg::CMD_READ) ? CRD_W'(r_row_in) : row_q;
    assign col_sel = (r_cmd == pgh_pkg::CMD_READ) ? CRD_W'(r_col_in) : col_q;

    // Clamp the grid width to the column count; a non-positive span gives 0
    always_comb begin
        if (!r_span_pos) begin
            width_c = '0;
        end else if (span_q > COLS_Q) begin
            width_c = COLS_W;
        end else begin
            width_c = span_q[WCOL_W-1:0];
        end
    end

    assign idx_c    = IDX_W'(r_prod) + IDX_W'(col_sel);
    assign out_free = !r_out_valid || i_m_tready;
    assign wb_go    = (r_state == pgh_pkg::ST_WRITE) && out_free;

    // Hit-count store
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CNT_W-1:0]  ram_wdata;
    logic [CNT_W-1:0]  ram_rdata;
    logic [CNT_W-1:0]  sat_inc;

    assign sat_inc = (ram_rdata == {CNT_W{1'b1}}) ? ram_rdata : ram_rdata + 1'b1;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx[ADDR_W-1:0];
        ram_wdata = '0;
        if (r_state == pgh_pkg::ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
        end else if (wb_go && r_hit) begin
            ram_we    = 1'b1;
            // Saturate on add; a read clears the cell
            ram_wdata = (r_cmd == pgh_pkg::CMD_ADD) ? sat_inc : '0;
        end
    end

    pgh_ram #(.DATA_W(CNT_W), .DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (r_state == pgh_pkg::ST_READ),
        .i_raddr (r_idx[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            pgh_pkg::ST_CLEAR: begin
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = pgh_pkg::ST_IDLE;
                end
            end
            pgh_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = pgh_pkg::ST_DIV;
                end
            end
            pgh_pkg::ST_DIV: begin
                if (div_done) begin
                    n_state = pgh_pkg::ST_MUL;
                end
            end
            pgh_pkg::ST_MUL:   n_state = pgh_pkg::ST_ADDR;
            pgh_pkg::ST_ADDR:  n_state = pgh_pkg::ST_READ;
            pgh_pkg::ST_READ:  n_state = pgh_pkg::ST_WRITE;
            pgh_pkg::ST_WRITE: begin
                if (out_free) begin
                    n_state = pgh_pkg::ST_IDLE;
                end
            end
            default: n_state = pgh_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pgh_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Clearing sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (r_state == pgh_pkg::ST_CLEAR) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // Item datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd      <= in_cmd;
            r_in_box   <= in_box;
            r_span_pos <= span_pos;
            r_row_in   <= in_row;
            r_col_in   <= in_col;
        end
        if (r_state == pgh_pkg::ST_DIV) begin
            r_width <= width_c;
        end
        if (r_state == pgh_pkg::ST_MUL) begin
            r_prod <= PROD_W'(row_sel) * PROD_W'(r_width);
        end
        if (r_state == pgh_pkg::ST_ADDR) begin
            // Drop adds outside the box and any index beyond the store
            r_idx <= idx_c;
            r_hit <= (idx_c < DEPTH_I)
                  && ((r_cmd == pgh_pkg::CMD_READ) || r_in_box);
        end
    end

    // Output beat: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (wb_go) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wb_go) begin
            r_out_counted <= (r_cmd == pgh_pkg::CMD_ADD) && r_hit;
            r_out_count   <= ((r_cmd == pgh_pkg::CMD_READ) && r_hit) ? ram_rdata : '0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = pgh_pkg::M_TDATA_W'({r_out_count, r_out_counted});

endmodule

// ===== rtl/core/pgh_ram.sv =====
module pgh_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/pgh_div.sv =====
module pgh_div #(
    parameter int NUM_W = 16,
    parameter int DEN_W = pgh_pkg::CELL_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic [NUM_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W+1:0] diff;

    // Shift one dividend bit into the remainder and try the subtraction
    assign rem_sh = {r_rem[DEN_W-1:0], r_num[NUM_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            if (!diff[DEN_W+1]) begin
                r_rem <= diff[DEN_W:0];
                r_num <= {r_num[NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_num <= {r_num[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_num;

endmodule

// ===== tb/point_grid_histogram_tb.sv =====
`timescale 1ns / 100ps

module point_grid_histogram_tb;
    import pgh_pkg::*;

    localparam int ROWS        = GRID_ROWS_DEF;
    localparam int COLS        = GRID_COLS_DEF;
    localparam int DEPTH       = ROWS * COLS;
    localparam int ADDR_SPAN   = 1 << IDX_IN_W;
    localparam int IDLE_PCT    = 22;
    // Clearing pass after reset plus every item at its slowest, taken several times
    localparam int CYCLE_LIMIT = 2_000_000;

    localparam logic [CFG_IDX_W-1:0] REG_ORDER [5] =
        '{CFG_CELL_SIZE, CFG_MIN_X, CFG_MAX_X, CFG_MIN_Y, CFG_MAX_Y};

    typedef logic signed [COORD_W-1:0] t_coord;

    // One result beat as it should leave the block
    typedef struct {
        logic               counted;
        logic [COUNT_W-1:0] count;
    } t_cell_beat;

    // Keeps its own copy of the grid and the registers, and predicts each result beat
    class grid_scoreboard;
        bit [COUNT_W-1:0] hits [DEPTH];
        bit [CELL_W-1:0]  cell_mm = CELL_SIZE_RST;
        t_coord           lo_x    = MIN_X_RST;
        t_coord           hi_x    = MAX_X_RST;
        t_coord           lo_y    = MIN_Y_RST;
        t_coord           hi_y    = MAX_Y_RST;
        t_cell_beat       due [$];
        int               errors;

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_CELL_SIZE: cell_mm = data[CELL_W-1:0];
                CFG_MIN_X:     lo_x    = data;
                CFG_MAX_X:     hi_x    = data;
                CFG_MIN_Y:     lo_y    = data;
                CFG_MAX_Y:     hi_y    = data;
                default: ;
            endcase
        endfunction

        // A cell size of zero behaves as one millimetre
        function int eff_cell();
            return (cell_mm == 0) ? 1 : int'(cell_mm);
        endfunction

        // Columns per row: x span plus margin over the cell size, floored at 0, capped
        function int grid_width();
            int span;
            int w;
            span = int'(hi_x) - int'(lo_x) + 1000;
            if (span <= 0)
                return 0;
            w = span / eff_cell();
            return (w > COLS) ? COLS : w;
        endfunction

        // Row and column of a point, if it lies strictly inside the box
        function bit bin_point(t_coord x, t_coord y, output int row, output int col);
            row = 0;
            col = 0;
            if (!(x > lo_x && x < hi_x && y > lo_y && y < hi_y))
                return 1'b0;
            row = (int'(y) - int'(lo_y)) / eff_cell();
            col = (int'(x) - int'(lo_x)) / eff_cell();
            return 1'b1;
        endfunction

        function void note_item(logic cmd, t_coord x, t_coord y,
                                logic [IDX_IN_W-1:0] row, logic [IDX_IN_W-1:0] col);
            t_cell_beat exp_beat;
            longint     idx;
            int         r;
            int         c;
            exp_beat = '{counted: 1'b0, count: '0};
            if (cmd == CMD_ADD) begin
                if (bin_point(x, y, r, c)) begin
                    idx = longint'(r) * grid_width() + c;
                    if (idx < DEPTH) begin
                        if (hits[idx] != '1)
                            hits[idx]++;
                        exp_beat.counted = 1'b1;
                    end
                end
            end else begin
                idx = longint'(row) * grid_width() + col;
                if (idx < DEPTH) begin
                    exp_beat.count = hits[idx];
                    hits[idx]      = '0;
                end
            end
            due.push_back(exp_beat);
        endfunction

        function void check_beat(logic [M_TDATA_W-1:0] beat);
            t_cell_beat exp_beat;
            if (due.size() == 0) begin
                $display("%0t: result beat %h with nothing outstanding", $time, beat);
                errors++;
                return;
            end
            exp_beat = due.pop_front();
            if (beat[0] !== exp_beat.counted) begin
                $display("%0t: point_counted expected %0d, actual %0d",
                         $time, exp_beat.counted, beat[0]);
                errors++;
            end
            if (beat[COUNT_W:1] !== exp_beat.count) begin
                $display("%0t: cell_count expected %0d, actual %0d",
                         $time, exp_beat.count, beat[COUNT_W:1]);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  s_tuser  = CMD_ADD;
    logic                  m_tready = 1'b0;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = CFG_CELL_SIZE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    wire                   o_s_tready;
    wire                   o_m_tvalid;
    wire [M_TDATA_W-1:0]   o_m_tdata;

    // Set for one phase: both sides run flat out, no idling at all
    bit              calm;
    int unsigned     cycles;
    grid_scoreboard  sb;

    point_grid_histogram dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        // [15:0] point_x, [31:16] point_y, [40:32] cell_row, [49:41] cell_col
        .i_s_tdata  (s_tdata),
        // [0] command
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        // [0] point_counted, [8:1] cell_count
        .o_m_tdata  (o_m_tdata),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Receiver: stall at random, change only on the falling edge
    always @(negedge i_clk)
        m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);

    // Take every result beat at the rising edge it is handed over
    always @(posedge i_clk)
        if (i_rst_n && o_m_tvalid && m_tready)
            sb.check_beat(o_m_tdata);

    // Watchdog: give up well past the slowest correct run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Random coordinate strictly between lo and hi; any value if the range is empty
    function automatic t_coord inside_coord(t_coord lo, t_coord hi);
        if (int'(hi) - int'(lo) < 2)
            return t_coord'($urandom);
        return t_coord'(int'(lo) + 1 + int'($urandom_range(int'(hi) - int'(lo) - 2)));
    endfunction

    // Present one beat from a falling edge; hold it until taken. Valid is lowered
    // only for idle gaps before a beat, so back-to-back beats keep it high without a glitch.
    task automatic send_item(logic cmd, t_coord x, t_coord y,
                             logic [IDX_IN_W-1:0] row, logic [IDX_IN_W-1:0] col);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= S_TDATA_W'({col, row, y, x});
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_item(cmd, x, y, row, col);
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every result is back, then let the pipeline settle
    task automatic finish_phase();
        s_tvalid <= 1'b0;
        while (sb.due.size() != 0)
            @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    // Write all five registers, one per cycle, while the block is idle
    task automatic load_box(int cell_size, int lx, int hx, int ly, int hy);
        logic [CFG_DATA_W-1:0] vals [5];
        vals[0] = CFG_DATA_W'(cell_size);
        vals[1] = CFG_DATA_W'(lx);
        vals[2] = CFG_DATA_W'(hx);
        vals[3] = CFG_DATA_W'(ly);
        vals[4] = CFG_DATA_W'(hy);
        for (int i = 0; i < 5; i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= REG_ORDER[i];
            cfg_data <= vals[i];
            sb.write_reg(REG_ORDER[i], vals[i]);
            @(negedge i_clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Mostly well-formed traffic: adds that pile onto a few hot points or land
    // inside the box, reads that hit those same cells; the rest is noise.
    task automatic run_random(int n, int read_pct);
        t_coord              hot_x [8];
        t_coord              hot_y [8];
        t_coord              x;
        t_coord              y;
        logic [IDX_IN_W-1:0] row;
        logic [IDX_IN_W-1:0] col;
        logic                cmd;
        int                  r;
        int                  c;
        int                  k;
        int                  pick;
        for (int i = 0; i < 8; i++) begin
            hot_x[i] = inside_coord(sb.lo_x, sb.hi_x);
            hot_y[i] = inside_coord(sb.lo_y, sb.hi_y);
        end
        for (int n_done = 0; n_done < n; n_done++) begin
            x    = t_coord'($urandom);
            y    = t_coord'($urandom);
            row  = IDX_IN_W'($urandom);
            col  = IDX_IN_W'($urandom);
            pick = $urandom_range(99);
            k    = $urandom_range(7);
            if ($urandom_range(99) < read_pct) begin
                cmd = CMD_READ;
                if (pick < 50) begin
                    if (sb.bin_point(hot_x[k], hot_y[k], r, c) &&
                        r < ADDR_SPAN && c < ADDR_SPAN) begin
                        row = IDX_IN_W'(r);
                        col = IDX_IN_W'(c);
                    end
                end else if (pick < 70) begin
                    // low corner of the grid, where narrow grids keep their counts
                    row = IDX_IN_W'($urandom_range(3));
                    col = IDX_IN_W'($urandom_range(3));
                end
            end else begin
                cmd = CMD_ADD;
                if (pick < 50) begin
                    x = hot_x[k];
                    y = hot_y[k];
                end else if (pick < 80) begin
                    x = inside_coord(sb.lo_x, sb.hi_x);
                    y = inside_coord(sb.lo_y, sb.hi_y);
                end
            end
            send_item(cmd, x, y, row, col);
        end
    endtask

    initial begin
        int lx;
        int ly;
        sb = new();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed beats on the reset registers: 50 mm cells, box +-10 m, 420 columns.
        // Tready stays low through the clearing pass, so the first beat simply waits.
        send_item(CMD_ADD,  -16'sd9999,  -16'sd9999,  '0, '0);   // first cell
        send_item(CMD_ADD,  -16'sd9999,  -16'sd9999,  '0, '0);
        send_item(CMD_ADD,   16'sd9999,   16'sd9999,  '0, '0);   // last cell of the box
        send_item(CMD_ADD,   16'sd0,      16'sd0,     '0, '0);
        send_item(CMD_ADD,  -16'sd10000,  16'sd0,     '0, '0);   // on each bound: rejected
        send_item(CMD_ADD,   16'sd10000,  16'sd0,     '0, '0);
        send_item(CMD_ADD,   16'sd0,     -16'sd10000, '0, '0);
        send_item(CMD_ADD,   16'sd0,      16'sd10000, '0, '0);
        send_item(CMD_ADD,  -16'sd32768, -16'sd32768, '1, '1);   // coordinate extremes
        send_item(CMD_ADD,   16'sd32767,  16'sd32767, '0, '1);
        send_item(CMD_ADD,  -16'sd32768,  16'sd32767, '1, '0);
        send_item(CMD_ADD,  -16'sd9951,  -16'sd9951,  '0, '0);   // just short of the next cell, still the first
        send_item(CMD_READ,  16'sd0,      16'sd0,     9'd0,   9'd0);
        send_item(CMD_READ,  16'sd0,      16'sd0,     9'd0,   9'd0);   // cleared by the last read
        send_item(CMD_READ, -16'sd1,     -16'sd1,     9'd399, 9'd399);
        send_item(CMD_READ,  16'sd0,      16'sd0,     9'd200, 9'd200);
        send_item(CMD_READ,  16'sd0,      16'sd0,     9'd1,   9'd1);
        send_item(CMD_READ,  16'sd0,      16'sd0,     9'd511, 9'd511);
        send_item(CMD_READ,  16'sd0,      16'sd0,     9'd0,   9'd511); // column spills into row 1
        run_random(150, 25);
        finish_phase();

        // One-millimetre cells: width capped at the grid, most rows fall off the store
        load_box(1, -10000, 10000, -10000, 10000);
        run_random(150, 25);
        finish_phase();

        // Zero cell size, full-range x: run this phase with no idling on either side
        calm = 1'b1;
        load_box(0, -32768, 32767, -300, 300);
        run_random(150, 25);
        finish_phase();
        calm = 1'b0;

        // Width of zero: every point in the box lands on one cell until it saturates
        load_box(10000, -100, 100, -100, 100);
        run_random(330, 0);
        run_random(40, 30);
        finish_phase();

        // Inverted x box and largest cell code: nothing counted, reads see column only
        load_box(16383, 32767, -32768, -32768, 32767);
        run_random(100, 40);
        finish_phase();

        // A random small box
        lx = int'($urandom_range(4000)) - 2000;
        ly = int'($urandom_range(4000)) - 2000;
        load_box($urandom_range(1, 300), lx, lx + int'($urandom_range(2, 6000)),
                 ly, ly + int'($urandom_range(2, 6000)));
        run_random(200, 25);
        finish_phase();

        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
